@@ hdl/npc16_pkg.sv @@
// Shared types, palette levels and level tables for the 16-color nearest-match pipeline.
`default_nettype none
package npc16_pkg;

	localparam int NUM_COLORS = 16;
	localparam int NUM_LEVELS = 4;
	localparam int NUM_CHAN   = 3;
	localparam int DIST_W     = 18;
	localparam int SQ_W       = 16;
	localparam int IDX_W      = 4;

	localparam logic [IDX_W-1:0] IDX_BLACK = 4'd0;
	localparam logic [IDX_W-1:0] IDX_WHITE = 4'd15;

	// Channel order within packed arrays
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	localparam logic [7:0] LEVEL [0:NUM_LEVELS-1] = '{8'h00, 8'h54, 8'ha8, 8'hfc};

	// Level code of each palette entry, per channel
	localparam logic [1:0] RED_LVL [0:NUM_COLORS-1] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3
	};
	localparam logic [1:0] GREEN_LVL [0:NUM_COLORS-1] = '{
		2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd2,
		2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3
	};
	localparam logic [1:0] BLUE_LVL [0:NUM_COLORS-1] = '{
		2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2,
		2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3
	};

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [NUM_COLORS-1:0][DIST_W-1:0] dist_arr_t;

endpackage
`default_nettype wire

@@ hdl/nearest_palette_color_16.sv @@
// Top level: nearest 16-color text-mode palette match, five-stage pipeline.
//
//  channel   ports                   handshake
//  input     start, pixel_rgb        taken when start && !busy
//  result    done, color_index       one-cycle strobe on done
//
// One pixel may enter every cycle; its index appears on done once it leaves the last stage.
// Stages: channel differences, squares (twelve 8x8 multipliers), per-entry sums,
// then two stages of the 16-way minimum tree.
// Reset clears the valid bits only; nothing is in flight afterwards.
// busy stays low: the pipeline has no stall path.
`default_nettype none
module nearest_palette_color_16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [23:0] pixel_rgb,
	output logic             done,
	output logic [3:0]       color_index
);

	npc16_pkg::dist_arr_t dists;
	logic dist_valid;

	assign busy = 1'b0;

	npc16_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pixel_rgb (pixel_rgb),
		.out_valid (dist_valid),
		.dists     (dists)
	);

	npc16_argmin u_argmin (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (dist_valid),
		.dists       (dists),
		.out_valid   (done),
		.color_index (color_index)
	);

	// Every accepted word produces a result on done
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("accepted word did not produce a result");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without a matching input word");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		start && pixel_rgb == 24'h000000 |-> ##5 color_index == npc16_pkg::IDX_BLACK)
		else $error("black pixel not mapped to black");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		start && pixel_rgb == 24'hffffff |-> ##5 color_index == npc16_pkg::IDX_WHITE)
		else $error("white pixel not mapped to white");

endmodule
`default_nettype wire

@@ hdl/npc16_dist.sv @@
// Distance stages: per-channel differences, squares, and per-entry sums.
`default_nettype none
module npc16_dist (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [23:0]         pixel_rgb,
	output logic                     out_valid,
	output npc16_pkg::dist_arr_t     dists
);

	logic [npc16_pkg::NUM_CHAN-1:0][npc16_pkg::NUM_LEVELS-1:0][7:0] diff_d;
	logic [npc16_pkg::NUM_CHAN-1:0][npc16_pkg::NUM_LEVELS-1:0][7:0] diff_s1;
	logic [npc16_pkg::NUM_CHAN-1:0][npc16_pkg::NUM_LEVELS-1:0][npc16_pkg::SQ_W-1:0] sq_s2;
	npc16_pkg::dist_arr_t dist_d;
	npc16_pkg::dist_arr_t dist_s3;
	logic valid_s1, valid_s2, valid_s3;

	// Absolute difference of each channel against each of the four levels
	always_comb begin
		for (int c = 0; c < npc16_pkg::NUM_CHAN; c++) begin
			for (int l = 0; l < npc16_pkg::NUM_LEVELS; l++) begin
				if (pixel_rgb[8*c +: 8] >= npc16_pkg::LEVEL[l]) begin
					diff_d[c][l] = pixel_rgb[8*c +: 8] - npc16_pkg::LEVEL[l];
				end else begin
					diff_d[c][l] = npc16_pkg::LEVEL[l] - pixel_rgb[8*c +: 8];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < npc16_pkg::NUM_COLORS; k++) begin
			dist_d[k] = npc16_pkg::DIST_W'(sq_s2[npc16_pkg::CH_RED][npc16_pkg::RED_LVL[k]])
				+ npc16_pkg::DIST_W'(sq_s2[npc16_pkg::CH_GREEN][npc16_pkg::GREEN_LVL[k]])
				+ npc16_pkg::DIST_W'(sq_s2[npc16_pkg::CH_BLUE][npc16_pkg::BLUE_LVL[k]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_d;
		for (int c = 0; c < npc16_pkg::NUM_CHAN; c++) begin
			for (int l = 0; l < npc16_pkg::NUM_LEVELS; l++) begin
				sq_s2[c][l] <= npc16_pkg::SQ_W'(diff_s1[c][l])
					* npc16_pkg::SQ_W'(diff_s1[c][l]);
			end
		end
		dist_s3 <= dist_d;
	end

	assign out_valid = valid_s3;
	assign dists     = dist_s3;

endmodule
`default_nettype wire

@@ hdl/npc16_argmin.sv @@
// Two-stage minimum tree over the 16 distances; lower index wins a tie.
`default_nettype none
module npc16_argmin (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire npc16_pkg::dist_arr_t           dists,
	output logic                                out_valid,
	output logic [npc16_pkg::IDX_W-1:0]         color_index
);

	npc16_pkg::dist_t lo_d [0:7];
	logic [npc16_pkg::IDX_W-1:0] lo_i [0:7];
	npc16_pkg::dist_t grp_d [0:3];
	logic [npc16_pkg::IDX_W-1:0] grp_i [0:3];
	npc16_pkg::dist_t min_d_s4 [0:3];
	logic [npc16_pkg::IDX_W-1:0] min_i_s4 [0:3];
	npc16_pkg::dist_t hi_d [0:1];
	logic [npc16_pkg::IDX_W-1:0] hi_i [0:1];
	logic [npc16_pkg::IDX_W-1:0] best_i;
	logic [npc16_pkg::IDX_W-1:0] color_index_s5;
	logic valid_s4, valid_s5;

	// Stage 4: 16 -> 8 -> 4; take the upper candidate only when strictly closer
	always_comb begin
		for (int p = 0; p < 8; p++) begin
			if (dists[2*p+1] < dists[2*p]) begin
				lo_d[p] = dists[2*p+1];
				lo_i[p] = npc16_pkg::IDX_W'(2*p+1);
			end else begin
				lo_d[p] = dists[2*p];
				lo_i[p] = npc16_pkg::IDX_W'(2*p);
			end
		end
		for (int g = 0; g < 4; g++) begin
			if (lo_d[2*g+1] < lo_d[2*g]) begin
				grp_d[g] = lo_d[2*g+1];
				grp_i[g] = lo_i[2*g+1];
			end else begin
				grp_d[g] = lo_d[2*g];
				grp_i[g] = lo_i[2*g];
			end
		end
	end

	// Stage 5: 4 -> 2 -> 1
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			if (min_d_s4[2*p+1] < min_d_s4[2*p]) begin
				hi_d[p] = min_d_s4[2*p+1];
				hi_i[p] = min_i_s4[2*p+1];
			end else begin
				hi_d[p] = min_d_s4[2*p];
				hi_i[p] = min_i_s4[2*p];
			end
		end
		best_i = (hi_d[1] < hi_d[0]) ? hi_i[1] : hi_i[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < 4; g++) begin
			min_d_s4[g] <= grp_d[g];
			min_i_s4[g] <= grp_i[g];
		end
		color_index_s5 <= best_i;
	end

	assign out_valid   = valid_s5;
	assign color_index = color_index_s5;

endmodule
`default_nettype wire
